// ===== rtl/bfi_pkg.sv =====
// Package for the tape-language interpreter core.
// Commands, status codes, run phases, sizes and the sequencer state type.
// No dependencies.
package bfi_pkg;

	localparam int unsigned PROG_DEPTH_DEF  = 4096;
	localparam int unsigned TAPE_DEPTH_DEF  = 32768;
	localparam int unsigned STACK_DEPTH_DEF = 64;

	localparam int unsigned CMD_W    = 3;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned IP_W     = 13;
	localparam int unsigned DP_W     = 15;

	typedef enum logic [2:0] {
		CMD_LOAD   = 3'd0,
		CMD_FINISH = 3'd1,
		CMD_STEP   = 3'd2,
		CMD_RESET  = 3'd3,
		CMD_NEW    = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_END       = 3'd1,
		ST_LIMIT     = 3'd2,
		ST_STACKOVER = 3'd3,
		ST_UNMATCHED = 3'd4,
		ST_TOOLONG   = 3'd5,
		ST_NOTLOADED = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		PH_LOADING = 2'd0,
		PH_READY   = 2'd1,
		PH_HALTED  = 2'd2,
		PH_FAILED  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_CLOSE,
		S_CLEAR,
		S_OUT
	} state_t;

	localparam logic [7:0] CH_INC_DP = 8'h3E;
	localparam logic [7:0] CH_DEC_DP = 8'h3C;
	localparam logic [7:0] CH_INC    = 8'h2B;
	localparam logic [7:0] CH_DEC    = 8'h2D;
	localparam logic [7:0] CH_OUT    = 8'h2E;
	localparam logic [7:0] CH_IN     = 8'h2C;
	localparam logic [7:0] CH_OPEN   = 8'h5B;
	localparam logic [7:0] CH_CLOSE  = 8'h5D;

	localparam int unsigned REG_STEP_LIMIT = 0;

endpackage

// ===== rtl/bfi_if.sv =====
// Valid/ready channel interfaces for the interpreter core.
// Depends on bfi_pkg.
interface bfi_in_if;
	logic                        valid;
	logic                        ready;
	logic [bfi_pkg::CMD_W-1:0]   cmd;
	logic [7:0]                  prog_char;
	logic [7:0]                  in_byte;
	logic                        in_eof;
	modport source (output valid, cmd, prog_char, in_byte, in_eof, input ready);
	modport sink (input valid, cmd, prog_char, in_byte, in_eof, output ready);
endinterface

interface bfi_out_if;
	logic                         valid;
	logic                         ready;
	logic [bfi_pkg::STATUS_W-1:0] status;
	logic                         out_valid;
	logic [7:0]                   out_byte;
	logic [bfi_pkg::IP_W-1:0]     cur_ip;
	logic [bfi_pkg::DP_W-1:0]     cur_dp;
	modport source (output valid, status, out_valid, out_byte, cur_ip, cur_dp, input ready);
	modport sink (input valid, status, out_valid, out_byte, cur_ip, cur_dp, output ready);
endinterface

// ===== rtl/bfi_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module bfi_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/brainfuck_interpreter_core.sv =====
// Top level of the tape-language interpreter core.
// Depends on bfi_pkg, bfi_if and bfi_ram.
//
// One transaction in, one result out. Load, finish, a step that does not
// execute, and unknown commands go straight to S_OUT. An executed step
// passes through S_EXEC: the program, jump-table and tape reads are shared,
// registered by the RAMs when the step is accepted, then S_EXEC executes
// and writes back. A ']' load passes through S_CLOSE; it writes its own
// jump entry in S_CLOSE and its partner's on entering S_OUT. Reset run and
// new program clear the tape one cell per cycle in S_CLEAR, a sweep over
// all TAPE_DEPTH cells. The same sweep runs once after reset before any
// item is accepted. The result sits in an output register; the next item
// is taken once it is delivered.
module brainfuck_interpreter_core #(
	parameter int unsigned PROG_DEPTH  = bfi_pkg::PROG_DEPTH_DEF,
	parameter int unsigned TAPE_DEPTH  = bfi_pkg::TAPE_DEPTH_DEF,
	parameter int unsigned STACK_DEPTH = bfi_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bfi_in_if.sink      in_ch,
	bfi_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int unsigned PA = $clog2(PROG_DEPTH);
	localparam int unsigned TA = $clog2(TAPE_DEPTH);
	localparam int unsigned SA = $clog2(STACK_DEPTH);
	localparam int unsigned PL = PA + 1;
	localparam int unsigned SL = SA + 1;

	logic [31:0] lim_q;
	assign pready = 1'b1;
	assign prdata = (paddr[1:0] == 2'(bfi_pkg::REG_STEP_LIMIT * 4)) ? lim_q : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= '0;
		end else if (psel && penable && pwrite
				&& paddr == 2'(bfi_pkg::REG_STEP_LIMIT * 4)) begin
			lim_q <= pwdata;
		end
	end

	bfi_pkg::state_t state_q, state_d;
	bfi_pkg::phase_t phase_q;
	logic [PL-1:0] plen_q, ip_q;
	logic [TA-1:0] dp_q, clr_q;
	logic [SL-1:0] sp_q;
	logic [31:0]   cnt_q;
	logic [7:0]    ib_q;
	logic          eof_q;
	logic [PA-1:0] jmp_pos_q;
	logic [PA-1:0] jmp_open_q;
	logic [2:0]    st_q;
	logic          ov_q;
	logic [7:0]    ob_q;
	logic          close_pend_q;
	logic          boot_q;

	logic          pm_we, jt_we, tp_we, bs_we;
	logic [PA-1:0] pm_wa, jt_wa, pm_ra, jt_ra;
	logic [7:0]    pm_wd, pm_rd, tp_wd, tp_rd;
	logic [PA-1:0] jt_wd, jt_rd, bs_wd, bs_rd;
	logic [TA-1:0] tp_wa;
	logic [SA-1:0] bs_wa, bs_ra;

	bfi_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog (
		.clk, .we(pm_we), .waddr(pm_wa), .wdata(pm_wd), .raddr(pm_ra), .rdata(pm_rd));
	bfi_ram #(.WIDTH(PA), .DEPTH(PROG_DEPTH)) u_jump (
		.clk, .we(jt_we), .waddr(jt_wa), .wdata(jt_wd), .raddr(jt_ra), .rdata(jt_rd));
	bfi_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
		.clk, .we(tp_we), .waddr(tp_wa), .wdata(tp_wd), .raddr(dp_q), .rdata(tp_rd));
	bfi_ram #(.WIDTH(PA), .DEPTH(STACK_DEPTH)) u_stack (
		.clk, .we(bs_we), .waddr(bs_wa), .wdata(bs_wd), .raddr(bs_ra), .rdata(bs_rd));

	logic acc;
	assign in_ch.ready = (state_q == bfi_pkg::S_IDLE);
	assign acc = in_ch.valid && in_ch.ready;

	logic [SA-1:0] sp_dec;
	assign sp_dec = SA'(sp_q - SL'(1));
	assign pm_ra = ip_q[PA-1:0];
	assign jt_ra = ip_q[PA-1:0];
	assign bs_ra = sp_dec;

	logic is_load, ld_ok, ld_open, ld_close;
	logic [7:0] ch_in;
	assign ch_in    = in_ch.prog_char;
	assign is_load  = acc && in_ch.cmd == bfi_pkg::CMD_LOAD && phase_q == bfi_pkg::PH_LOADING;
	assign ld_open  = ch_in == bfi_pkg::CH_OPEN;
	assign ld_close = ch_in == bfi_pkg::CH_CLOSE;
	assign ld_ok    = is_load && plen_q < PL'(PROG_DEPTH)
		&& !(ld_open && sp_q >= SL'(STACK_DEPTH)) && !(ld_close && sp_q == '0);

	logic run_ok, do_exec;
	assign run_ok = (phase_q == bfi_pkg::PH_READY || phase_q == bfi_pkg::PH_HALTED)
		&& ip_q < plen_q && !(lim_q != 0 && cnt_q >= lim_q);
	assign do_exec = state_q == bfi_pkg::S_EXEC;

	logic [7:0] tp_new;
	logic       jump_tk;
	logic [PL-1:0] ip_nx;
	always_comb begin
		tp_new  = tp_rd;
		jump_tk = 1'b0;
		unique case (pm_rd)
			bfi_pkg::CH_INC:   tp_new = tp_rd + 8'd1;
			bfi_pkg::CH_DEC:   tp_new = tp_rd - 8'd1;
			bfi_pkg::CH_IN:    tp_new = eof_q ? 8'd0 : ib_q;
			bfi_pkg::CH_OPEN:  jump_tk = tp_rd == 8'd0;
			bfi_pkg::CH_CLOSE: jump_tk = tp_rd != 8'd0;
			default:           tp_new = tp_rd;
		endcase
		ip_nx = (jump_tk ? {1'b0, jt_rd} : ip_q) + PL'(1);
	end

	always_comb begin
		pm_we = ld_ok;
		pm_wa = plen_q[PA-1:0];
		pm_wd = ch_in;
		bs_we = ld_ok && ld_open;
		bs_wa = sp_q[SA-1:0];
		bs_wd = plen_q[PA-1:0];
		jt_we = 1'b0;
		jt_wa = jmp_open_q;
		jt_wd = jmp_pos_q;
		if (state_q == bfi_pkg::S_CLOSE) begin
			jt_we = 1'b1;
			jt_wa = jmp_pos_q;
			jt_wd = bs_rd;
		end else if (close_pend_q) begin
			// partner entry: open -> close
			jt_we = 1'b1;
		end
		if (state_q == bfi_pkg::S_CLEAR) begin
			tp_we = 1'b1;
			tp_wa = clr_q;
			tp_wd = 8'd0;
		end else begin
			tp_we = do_exec;
			tp_wa = dp_q;
			tp_wd = tp_new;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfi_pkg::S_IDLE: begin
				if (acc) begin
					if (in_ch.cmd == bfi_pkg::CMD_RESET || in_ch.cmd == bfi_pkg::CMD_NEW)
						state_d = bfi_pkg::S_CLEAR;
					else if (in_ch.cmd == bfi_pkg::CMD_STEP && run_ok)
						state_d = bfi_pkg::S_EXEC;
					else if (ld_ok && ld_close)
						state_d = bfi_pkg::S_CLOSE;
					else
						state_d = bfi_pkg::S_OUT;
				end
			end
			bfi_pkg::S_EXEC:  state_d = bfi_pkg::S_OUT;
			bfi_pkg::S_CLOSE: state_d = bfi_pkg::S_OUT;
			bfi_pkg::S_CLEAR: begin
				if (clr_q == TA'(TAPE_DEPTH - 1))
					state_d = boot_q ? bfi_pkg::S_IDLE : bfi_pkg::S_OUT;
			end
			bfi_pkg::S_OUT: begin
				if (out_ch.ready)
					state_d = bfi_pkg::S_IDLE;
			end
			default: state_d = bfi_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		out_ch.valid     = state_q == bfi_pkg::S_OUT;
		out_ch.status    = st_q;
		out_ch.out_valid = ov_q;
		out_ch.out_byte  = ob_q;
		out_ch.cur_ip    = bfi_pkg::IP_W'(ip_q);
		out_ch.cur_dp    = bfi_pkg::DP_W'(dp_q);
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ib_q      <= in_ch.in_byte;
			eof_q     <= in_ch.in_eof;
			jmp_pos_q <= plen_q[PA-1:0];
		end
		if (state_q == bfi_pkg::S_CLOSE) begin
			jmp_open_q <= bs_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bfi_pkg::S_CLEAR;
			phase_q      <= bfi_pkg::PH_LOADING;
			plen_q       <= '0;
			ip_q         <= '0;
			dp_q         <= '0;
			clr_q        <= '0;
			sp_q         <= '0;
			cnt_q        <= '0;
			st_q         <= bfi_pkg::ST_OK;
			ov_q         <= 1'b0;
			ob_q         <= 8'd0;
			close_pend_q <= 1'b0;
			boot_q       <= 1'b1;
		end else begin
			state_q <= state_d;
			close_pend_q <= state_q == bfi_pkg::S_CLOSE;
			if (state_q == bfi_pkg::S_CLEAR) begin
				clr_q <= clr_q + TA'(1);
				if (clr_q == TA'(TAPE_DEPTH - 1))
					boot_q <= 1'b0;
			end
			if (acc) begin
				st_q  <= bfi_pkg::ST_OK;
				ov_q  <= 1'b0;
				ob_q  <= 8'd0;
				clr_q <= '0;
				unique case (in_ch.cmd)
					bfi_pkg::CMD_LOAD: begin
						if (is_load) begin
							if (plen_q >= PL'(PROG_DEPTH)) begin
								phase_q <= bfi_pkg::PH_FAILED;
								st_q    <= bfi_pkg::ST_TOOLONG;
							end else if (ld_open && sp_q >= SL'(STACK_DEPTH)) begin
								phase_q <= bfi_pkg::PH_FAILED;
								st_q    <= bfi_pkg::ST_STACKOVER;
							end else if (ld_close && sp_q == '0) begin
								phase_q <= bfi_pkg::PH_FAILED;
								st_q    <= bfi_pkg::ST_UNMATCHED;
							end else begin
								plen_q <= plen_q + PL'(1);
								if (ld_open)
									sp_q <= sp_q + SL'(1);
								else if (ld_close)
									sp_q <= sp_q - SL'(1);
							end
						end
					end
					bfi_pkg::CMD_FINISH: begin
						if (phase_q == bfi_pkg::PH_LOADING) begin
							if (sp_q != '0) begin
								phase_q <= bfi_pkg::PH_FAILED;
								st_q    <= bfi_pkg::ST_UNMATCHED;
							end else begin
								phase_q <= bfi_pkg::PH_READY;
							end
						end else if (phase_q == bfi_pkg::PH_FAILED) begin
							st_q <= bfi_pkg::ST_NOTLOADED;
						end
					end
					bfi_pkg::CMD_STEP: begin
						if (phase_q == bfi_pkg::PH_LOADING || phase_q == bfi_pkg::PH_FAILED) begin
							st_q <= bfi_pkg::ST_NOTLOADED;
						end else if (ip_q >= plen_q) begin
							phase_q <= bfi_pkg::PH_HALTED;
							st_q    <= bfi_pkg::ST_END;
						end else if (lim_q != 0 && cnt_q >= lim_q) begin
							phase_q <= bfi_pkg::PH_HALTED;
							st_q    <= bfi_pkg::ST_LIMIT;
						end
					end
					bfi_pkg::CMD_RESET: begin
						dp_q  <= '0;
						ip_q  <= '0;
						cnt_q <= '0;
						if (phase_q == bfi_pkg::PH_HALTED)
							phase_q <= bfi_pkg::PH_READY;
					end
					bfi_pkg::CMD_NEW: begin
						dp_q    <= '0;
						ip_q    <= '0;
						cnt_q   <= '0;
						plen_q  <= '0;
						sp_q    <= '0;
						phase_q <= bfi_pkg::PH_LOADING;
					end
					default: st_q <= bfi_pkg::ST_OK;
				endcase
			end
			if (do_exec) begin
				if (cnt_q != 32'hFFFF_FFFF)
					cnt_q <= cnt_q + 32'd1;
				if (pm_rd == bfi_pkg::CH_INC_DP)
					dp_q <= (dp_q == TA'(TAPE_DEPTH - 1)) ? '0 : dp_q + TA'(1);
				else if (pm_rd == bfi_pkg::CH_DEC_DP)
					dp_q <= (dp_q == '0) ? TA'(TAPE_DEPTH - 1) : dp_q - TA'(1);
				if (pm_rd == bfi_pkg::CH_OUT) begin
					ov_q <= 1'b1;
					ob_q <= tp_rd;
				end
				ip_q <= ip_nx;
				if (ip_nx >= plen_q) begin
					phase_q <= bfi_pkg::PH_HALTED;
					st_q    <= bfi_pkg::ST_END;
				end
			end
		end
	end
endmodule
